FILE: rtl/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

`ifndef SYNTHESIS
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg)
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/rmq_pkg.sv
// Shared constants and types of the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none

package rmq_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 14;

    // raw quaternion components are held as sign and 31-bit magnitude
    localparam int RAW_W = 31;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/rmq_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on rmq_pkg.
`default_nettype none

module rmq_isqrt
    import rmq_pkg::*;
#(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 1,
    localparam int EW    = IN_W + (IN_W % 2),
    localparam int RW    = EW / 2
)(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctl_t         ctl,
    input  logic [IN_W-1:0]   rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int REMW = RW + 3;

    logic              vld_reg  [0:RW-1];
    logic [EW-1:0]     x_reg    [0:RW-1];
    logic [REMW-1:0]   rem_reg  [0:RW-1];
    logic [RW-1:0]     root_reg [0:RW-1];
    logic [SIDE_W-1:0] side_reg [0:RW-1];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_stage
            logic              vld_in;
            logic [EW-1:0]     x_in;
            logic [REMW-1:0]   rem_in;
            logic [RW-1:0]     root_in;
            logic [SIDE_W-1:0] sd_in;
            logic [REMW-1:0]   rem_sh;
            logic [REMW-1:0]   trial;
            logic [REMW-1:0]   rem_next;
            logic [RW-1:0]     root_next;

            if (i == 0)
            begin : g_first
                assign vld_in  = ctl.valid;
                assign x_in    = EW'(rad);
                assign rem_in  = '0;
                assign root_in = '0;
                assign sd_in   = side_in;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[i-1];
                assign x_in    = x_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign sd_in   = side_reg[i-1];
            end

            always_comb
            begin
                rem_sh = {rem_in[REMW-3:0], x_in[EW-1 -: 2]};
                trial  = {1'b0, root_in, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_in[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (ctl.en)
                    vld_reg[i] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    root_reg[i] <= root_next;
                    side_reg[i] <= sd_in;
                end
            end

            if (i < RW - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (ctl.en)
                    begin
                        x_reg[i]   <= {x_in[EW-3:0], 2'b00};
                        rem_reg[i] <= rem_next;
                    end
                end
            end
        end
    endgenerate

    assign valid_out = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

`default_nettype wire

FILE: rtl/rmq_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage,
// several lanes sharing one divisor. Depends on rmq_pkg.
`default_nettype none

module rmq_udiv
    import rmq_pkg::*;
#(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 17,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pipe_ctl_t                   ctl,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        valid_out,
    output logic [LANES-1:0][NUM_W-1:0] quo,
    output logic [SIDE_W-1:0]           side_out
);

    logic                        vld_reg  [0:NUM_W-1];
    logic [LANES-1:0][NUM_W-1:0] n_reg    [0:NUM_W-1];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [0:NUM_W-1];
    logic [DEN_W-1:0]            den_reg  [0:NUM_W-1];
    logic [SIDE_W-1:0]           side_reg [0:NUM_W-1];

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_stage
            logic                        vld_in;
            logic [LANES-1:0][NUM_W-1:0] n_in;
            logic [LANES-1:0][DEN_W-1:0] rem_in;
            logic [DEN_W-1:0]            den_in;
            logic [SIDE_W-1:0]           sd_in;
            logic [LANES-1:0][DEN_W:0]   rem_sh;
            logic [LANES-1:0][DEN_W:0]   diff;
            logic [LANES-1:0][DEN_W-1:0] rem_next;
            logic [LANES-1:0][NUM_W-1:0] n_next;

            if (i == 0)
            begin : g_first
                assign vld_in = ctl.valid;
                assign n_in   = num;
                assign rem_in = '0;
                assign den_in = den;
                assign sd_in  = side_in;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[i-1];
                assign n_in   = n_reg[i-1];
                assign rem_in = rem_reg[i-1];
                assign den_in = den_reg[i-1];
                assign sd_in  = side_reg[i-1];
            end

            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_sh[l] = {rem_in[l], n_in[l][NUM_W-1]};
                    diff[l]   = rem_sh[l] - {1'b0, den_in};
                    if (rem_sh[l] >= {1'b0, den_in})
                    begin
                        rem_next[l] = diff[l][DEN_W-1:0];
                        n_next[l]   = {n_in[l][NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = rem_sh[l][DEN_W-1:0];
                        n_next[l]   = {n_in[l][NUM_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (ctl.en)
                    vld_reg[i] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    n_reg[i]    <= n_next;
                    side_reg[i] <= sd_in;
                end
            end

            if (i < NUM_W - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (ctl.en)
                    begin
                        rem_reg[i] <= rem_next;
                        den_reg[i] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign valid_out = vld_reg[NUM_W-1];
    assign quo       = n_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd's method), fixed point.
// Depends on rmq_pkg, rmq_isqrt, rmq_udiv and the assertion macro header.
//
// Usage:
//   Input channel s_axis: one item is the nine matrix elements m00..m22,
//   signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS, packed into tdata.
//   Output channel m_axis: quaternion w, x, y, z in tdata (same format) and
//   the degenerate flag in tuser; a degenerate item carries zero quaternion.
//   Throughput: one item per cycle unless the receiver stalls (no internal stalls).
//   Stages in order: A, first square root (root width R1 = (max(W,F)+2+F)/2
//   rounded up), P, first divider (depth N1 = W+F+2), C, M, S1, S2, second
//   square root, Q, normalizing divider (depth N2 = F+32) and O; the roots
//   and dividers yield one bit per stage.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is dropped or repeated.
`default_nettype none
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int IN_TD_W    = ((9 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TD_W   = ((4 * DATA_WIDTH + 7) / 8) * 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  logic [IN_TD_W-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output logic [OUT_TD_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]          m_axis_tuser
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int MAXWF  = (W > F) ? W : F;
    localparam int MW     = MAXWF + 3;
    localparam int RAD_W  = MW - 1;
    localparam int SQ1_IN = RAD_W + F;
    localparam int SQ1_W  = (SQ1_IN + (SQ1_IN % 2)) / 2;
    localparam int OWN_W  = SQ1_W - 1;
    localparam int NW1    = W + F + 2;
    localparam int DEN1_W = SQ1_W + 1;
    localparam int CW     = (NW1 > RAW_W) ? NW1 : RAW_W;
    localparam int SQ_W   = 2 * RAW_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int LEN_W  = SUM_W / 2;
    localparam int NW2    = RAW_W + F + 1;
    localparam logic signed [MW-1:0] ONE_Q = MW'(1) << F;

    typedef struct packed {
        logic              deg;
        branch_t           br;
        logic [2:0]        sign;
        logic [2:0][W:0]   mag;
    } s1_side_t;

    typedef struct packed {
        logic              deg;
        branch_t           br;
        logic [2:0]        sign;
        logic [OWN_W-1:0]  own;
    } d1_side_t;

    typedef struct packed {
        logic                  deg;
        logic [3:0]            sign;
        logic [3:0][RAW_W-1:0] mag;
    } s2_side_t;

    typedef struct packed {
        logic       deg;
        logic [3:0] sign;
    } d2_side_t;

    logic en;

    // ---------------- stage A: trace, branch, radicand, numerators
    logic signed [W-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [MW-1:0] e00, e11, e22, tr, rad;
    logic signed [W:0]    n_d21, n_d02, n_d10, n_a01, n_a02, n_a12;
    logic signed [W:0]    nsel [0:2];
    branch_t              br;
    logic [2:0][W:0]      a_mag_next;
    logic [2:0]           a_sign_next;

    logic                 a_valid_reg;
    logic [RAD_W-1:0]     a_rad_reg;
    logic                 a_deg_reg;
    branch_t              a_br_reg;
    logic [2:0]           a_sign_reg;
    logic [2:0][W:0]      a_mag_reg;

    assign m00 = $signed(s_axis_tdata[0*W +: W]);
    assign m01 = $signed(s_axis_tdata[1*W +: W]);
    assign m02 = $signed(s_axis_tdata[2*W +: W]);
    assign m10 = $signed(s_axis_tdata[3*W +: W]);
    assign m11 = $signed(s_axis_tdata[4*W +: W]);
    assign m12 = $signed(s_axis_tdata[5*W +: W]);
    assign m20 = $signed(s_axis_tdata[6*W +: W]);
    assign m21 = $signed(s_axis_tdata[7*W +: W]);
    assign m22 = $signed(s_axis_tdata[8*W +: W]);

    always_comb
    begin
        e00   = MW'(m00);
        e11   = MW'(m11);
        e22   = MW'(m22);
        tr    = e00 + e11 + e22;
        n_d21 = (W+1)'(m21) - (W+1)'(m12);
        n_d02 = (W+1)'(m02) - (W+1)'(m20);
        n_d10 = (W+1)'(m10) - (W+1)'(m01);
        n_a01 = (W+1)'(m01) + (W+1)'(m10);
        n_a02 = (W+1)'(m02) + (W+1)'(m20);
        n_a12 = (W+1)'(m12) + (W+1)'(m21);
        priority if (tr > 0)
        begin
            br      = BR_TRACE;
            rad     = tr + ONE_Q;
            nsel[0] = n_d21;
            nsel[1] = n_d02;
            nsel[2] = n_d10;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            br      = BR_X;
            rad     = ONE_Q + e00 - e11 - e22;
            nsel[0] = n_d21;
            nsel[1] = n_a01;
            nsel[2] = n_a02;
        end
        else if (m11 > m22)
        begin
            br      = BR_Y;
            rad     = ONE_Q + e11 - e00 - e22;
            nsel[0] = n_d02;
            nsel[1] = n_a01;
            nsel[2] = n_a12;
        end
        else
        begin
            br      = BR_Z;
            rad     = ONE_Q + e22 - e00 - e11;
            nsel[0] = n_d10;
            nsel[1] = n_a02;
            nsel[2] = n_a12;
        end
        for (int k = 0; k < 3; k++)
        begin
            a_sign_next[k] = nsel[k][W];
            a_mag_next[k]  = nsel[k][W] ? $unsigned(-nsel[k]) : $unsigned(nsel[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rad_reg  <= rad[RAD_W-1:0];
            a_deg_reg  <= rad[MW-1] || (rad == '0);
            a_br_reg   <= br;
            a_sign_reg <= a_sign_next;
            a_mag_reg  <= a_mag_next;
        end
    end

    // ---------------- first square root
    pipe_ctl_t          s1_ctl;
    s1_side_t           s1_side_in, s1_side;
    logic               s1_valid;
    logic [SQ1_W-1:0]   s1_root;

    assign s1_ctl.en     = en;
    assign s1_ctl.valid  = a_valid_reg;
    assign s1_side_in    = '{deg: a_deg_reg, br: a_br_reg, sign: a_sign_reg, mag: a_mag_reg};

    rmq_isqrt #(
        .IN_W   (SQ1_IN),
        .SIDE_W ($bits(s1_side_t))
    ) u_sqrt_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s1_ctl),
        .rad       ({a_rad_reg, {F{1'b0}}}),
        .side_in   (s1_side_in),
        .valid_out (s1_valid),
        .root      (s1_root),
        .side_out  (s1_side)
    );

    // ---------------- stage P: rounded dividends and divisor s = 2 * sq
    logic                    p_valid_reg;
    logic [2:0][NW1-1:0]     p_num_reg;
    logic [DEN1_W-1:0]       p_den_reg;
    d1_side_t                p_side_reg;
    logic [2:0][NW1-1:0]     p_num_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            p_num_next[k] = NW1'({s1_side.mag[k], {F{1'b0}}}) + NW1'(s1_root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_num_reg  <= p_num_next;
            p_den_reg  <= {s1_root, 1'b0};
            p_side_reg <= '{deg: s1_side.deg, br: s1_side.br, sign: s1_side.sign,
                            own: s1_root[SQ1_W-1:1]};
        end
    end

    // ---------------- first divider
    pipe_ctl_t           d1_ctl;
    logic                d1_valid;
    logic [2:0][NW1-1:0] d1_quo;
    d1_side_t            d1_side;

    assign d1_ctl.en    = en;
    assign d1_ctl.valid = p_valid_reg;

    rmq_udiv #(
        .NUM_W  (NW1),
        .DEN_W  (DEN1_W),
        .LANES  (3),
        .SIDE_W ($bits(d1_side_t))
    ) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (d1_ctl),
        .num       (p_num_reg),
        .den       (p_den_reg),
        .side_in   (p_side_reg),
        .valid_out (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    // ---------------- stage C: place own component, clamp raw magnitudes
    logic                  c_valid_reg;
    logic                  c_deg_reg;
    logic [3:0]            c_sign_reg;
    logic [3:0][RAW_W-1:0] c_mag_reg;
    logic [3:0]            c_sign_next;
    logic [3:0][RAW_W-1:0] c_mag_next;
    logic [CW-1:0]         c_wide;
    logic [1:0]            c_j;

    always_comb
    begin
        c_wide = '0;
        c_j    = '0;
        for (int j = 0; j < 4; j++)
        begin
            c_j = 2'(j);
            priority if (c_j < d1_side.br)
            begin
                c_wide         = CW'(d1_quo[j]);
                c_sign_next[j] = d1_side.sign[j];
            end
            else if (c_j == d1_side.br)
            begin
                c_wide         = CW'(d1_side.own);
                c_sign_next[j] = 1'b0;
            end
            else
            begin
                c_wide         = CW'(d1_quo[j-1]);
                c_sign_next[j] = d1_side.sign[j-1];
            end
            c_mag_next[j] = (c_wide > CW'(RAW_MAX)) ? RAW_MAX : c_wide[RAW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_deg_reg  <= d1_side.deg;
            c_sign_reg <= c_sign_next;
            c_mag_reg  <= c_mag_next;
        end
    end

    // ---------------- stages M, S1, S2: squares and their sum
    logic                  mq_valid_reg, sa_valid_reg, sb_valid_reg;
    logic [3:0][SQ_W-1:0]  mq_sq_reg;
    logic [1:0][SQ_W:0]    sa_pair_reg;
    logic [SUM_W-1:0]      sb_sum_reg;
    s2_side_t              mq_side_reg, sa_side_reg, sb_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mq_valid_reg <= 1'b0;
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mq_valid_reg <= c_valid_reg;
            sa_valid_reg <= mq_valid_reg;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                mq_sq_reg[k] <= c_mag_reg[k] * c_mag_reg[k];
            mq_side_reg    <= '{deg: c_deg_reg, sign: c_sign_reg, mag: c_mag_reg};
            sa_pair_reg[0] <= (SQ_W+1)'(mq_sq_reg[0]) + (SQ_W+1)'(mq_sq_reg[1]);
            sa_pair_reg[1] <= (SQ_W+1)'(mq_sq_reg[2]) + (SQ_W+1)'(mq_sq_reg[3]);
            sa_side_reg    <= mq_side_reg;
            sb_sum_reg     <= SUM_W'(sa_pair_reg[0]) + SUM_W'(sa_pair_reg[1]);
            sb_side_reg    <= sa_side_reg;
        end
    end

    // ---------------- second square root: quaternion length
    pipe_ctl_t         s2_ctl;
    logic              s2_valid;
    logic [LEN_W-1:0]  s2_len;
    s2_side_t          s2_side;

    assign s2_ctl.en    = en;
    assign s2_ctl.valid = sb_valid_reg;

    rmq_isqrt #(
        .IN_W   (SUM_W),
        .SIDE_W ($bits(s2_side_t))
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s2_ctl),
        .rad       (sb_sum_reg),
        .side_in   (sb_side_reg),
        .valid_out (s2_valid),
        .root      (s2_len),
        .side_out  (s2_side)
    );

    // ---------------- stage Q: normalizing dividends
    logic                q_valid_reg;
    logic [3:0][NW2-1:0] q_num_reg;
    logic [LEN_W-1:0]    q_den_reg;
    d2_side_t            q_side_reg;
    logic [3:0][NW2-1:0] q_num_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            q_num_next[k] = NW2'({s2_side.mag[k], {F{1'b0}}}) + NW2'(s2_len[LEN_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (en)
            q_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_num_reg  <= q_num_next;
            q_den_reg  <= s2_len;
            q_side_reg <= '{deg: s2_side.deg || (s2_len == '0), sign: s2_side.sign};
        end
    end

    // ---------------- normalizing divider
    pipe_ctl_t           d2_ctl;
    logic                d2_valid;
    logic [3:0][NW2-1:0] d2_quo;
    d2_side_t            d2_side;

    assign d2_ctl.en    = en;
    assign d2_ctl.valid = q_valid_reg;

    rmq_udiv #(
        .NUM_W  (NW2),
        .DEN_W  (LEN_W),
        .LANES  (4),
        .SIDE_W ($bits(d2_side_t))
    ) u_div_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (d2_ctl),
        .num       (q_num_reg),
        .den       (q_den_reg),
        .side_in   (q_side_reg),
        .valid_out (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    // ---------------- stage O: saturate, output register
    logic                o_valid_reg;
    logic                o_deg_reg;
    logic [3:0][W-1:0]   o_data_reg;
    logic [3:0][W-1:0]   o_data_next;
    logic [NW2-1:0]      lim_pos, lim_neg;

    always_comb
    begin
        lim_pos = {{(NW2-W+1){1'b0}}, {(W-1){1'b1}}};
        lim_neg = lim_pos + NW2'(1);
        for (int k = 0; k < 4; k++)
        begin
            if (d2_side.deg)
                o_data_next[k] = '0;
            else if (d2_side.sign[k])
                o_data_next[k] = (d2_quo[k] > lim_neg) ? lim_neg[W-1:0]
                                                       : (~d2_quo[k][W-1:0] + W'(1));
            else
                o_data_next[k] = (d2_quo[k] > lim_pos) ? lim_pos[W-1:0] : d2_quo[k][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_data_reg <= o_data_next;
            o_deg_reg  <= d2_side.deg;
        end
    end

    assign en            = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'(o_data_reg);
    assign m_axis_tuser  = o_deg_reg;

    `RMQ_ASSERT_IMP(deg_zero_chk, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0,
        "degenerate item carries nonzero quaternion")
    `RMQ_ASSERT_IMP(root_nz_chk, s1_valid && !s1_side.deg, s1_root != '0,
        "zero root on a non-degenerate item")
    `RMQ_ASSERT_NXT(hold_chk, !en, $stable(a_valid_reg) && $stable(o_valid_reg),
        "pipeline advanced during stall")

endmodule

`default_nettype wire

FILE: sim/rmq_checker.sv
// Checker for the rotation matrix to quaternion block: watches both streams,
// predicts each quaternion from the accepted matrix and compares in order.
// Depends on rmq_pkg.
`timescale 1ns / 100ps

module rmq_checker
    import rmq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending
);

    localparam int FB = DEF_FRAC_BITS;
    localparam longint RAW_LIM = 64'sd2147483647;

    typedef struct packed {
        logic        degenerate;
        logic [15:0] qz;
        logic [15:0] qy;
        logic [15:0] qx;
        logic [15:0] qw;
    } quat_t;

    quat_t quat_queue[$];

    assign pending = quat_queue.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = ((mag << FB) + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic quat_t matrix_to_quat(logic [143:0] d);
        longint m[9];
        longint tr, rad, own;
        longint q[4];
        longint unsigned sq, s, sum, len, a;
        branch_t br;
        quat_t r;
        for (int i = 0; i < 9; i++)
            m[i] = longint'($signed(d[16*i +: 16]));
        r = '0;
        tr = m[0] + m[4] + m[8];
        if (tr > 0)
        begin
            br = BR_TRACE;
            rad = tr + (64'sd1 << FB);
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            br = BR_X;
            rad = (64'sd1 << FB) + m[0] - m[4] - m[8];
        end
        else if (m[4] > m[8])
        begin
            br = BR_Y;
            rad = (64'sd1 << FB) + m[4] - m[0] - m[8];
        end
        else
        begin
            br = BR_Z;
            rad = (64'sd1 << FB) + m[8] - m[0] - m[4];
        end
        if (rad <= 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        sq = int_sqrt(longint'(rad) << FB);
        s = 2 * sq;
        own = longint'(sq / 2);
        case (br)
            BR_TRACE:
            begin
                q[0] = own;                     q[1] = round_div(m[7] - m[5], s);
                q[2] = round_div(m[2] - m[6], s); q[3] = round_div(m[3] - m[1], s);
            end
            BR_X:
            begin
                q[0] = round_div(m[7] - m[5], s); q[1] = own;
                q[2] = round_div(m[1] + m[3], s); q[3] = round_div(m[2] + m[6], s);
            end
            BR_Y:
            begin
                q[0] = round_div(m[2] - m[6], s); q[1] = round_div(m[1] + m[3], s);
                q[2] = own;                     q[3] = round_div(m[5] + m[7], s);
            end
            default:
            begin
                q[0] = round_div(m[3] - m[1], s); q[1] = round_div(m[2] + m[6], s);
                q[2] = round_div(m[5] + m[7], s); q[3] = own;
            end
        endcase
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = clip(q[i], -RAW_LIM, RAW_LIM);
            a = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
            sum += a * a;
        end
        len = int_sqrt(sum);
        if (len == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        r.qw = 16'(clip(round_div(q[0], len), -32768, 32767));
        r.qx = 16'(clip(round_div(q[1], len), -32768, 32767));
        r.qy = 16'(clip(round_div(q[2], len), -32768, 32767));
        r.qz = 16'(clip(round_div(q[3], len), -32768, 32767));
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    initial
        fail_count = 0;

    always @(posedge clk)
    begin
        quat_t exp_q;
        quat_t act_q;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            quat_queue.push_back(matrix_to_quat(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act_q = {m_axis_tuser, m_axis_tdata};
            if (quat_queue.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result %h", $time, act_q);
            end
            else
            begin
                exp_q = quat_queue.pop_front();
                compare_field("quat_w", exp_q.qw, act_q.qw);
                compare_field("quat_x", exp_q.qx, act_q.qx);
                compare_field("quat_y", exp_q.qy, act_q.qy);
                compare_field("quat_z", exp_q.qz, act_q.qz);
                compare_field("degenerate", 16'(exp_q.degenerate), 16'(act_q.degenerate));
            end
        end
    end

endmodule

FILE: sim/tb_rotation_matrix_to_quaternion.sv
// Testbench top for the rotation matrix to quaternion block: drives directed
// and random matrices with random idling and gives the verdict.
// Depends on rmq_pkg, rmq_checker and the block's RTL.
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;

    localparam int LATENCY   = 134;
    localparam int N_RANDOM  = 450;
    localparam longint LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    logic         calm;
    logic         hold_req;
    logic         hold_off;
    longint       cycle_count;

    rotation_matrix_to_quaternion DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    rmq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("FAIL rotation_matrix_to_quaternion");
                $finish;
            end
        end
    end

    // hold off the receiver once asked, then release it
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req === 1'b1);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (LATENCY + 60) @(posedge clk);
        hold_off = 1'b0;
    end

    // receiver: random stalls, a long hold-off when asked, none while calm
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    function automatic logic [15:0] rot_elem();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'($urandom);
        else if (r < 3)
            return 16'($urandom_range(32767) - 16384);
        return 16'($urandom_range(32768) - 16384);
    endfunction

    function automatic logic [143:0] matrix_item(logic [15:0] a, b, c, d, e, f, g, h, k);
        return {k, h, g, f, e, d, c, b, a};
    endfunction

    // rotation-like matrix: for sel below 4 the diagonals are picked to steer the branch choice
    function automatic logic [143:0] random_matrix();
        logic [143:0] v;
        int sel;
        v = '0;
        sel = $urandom_range(4);
        for (int i = 0; i < 9; i++)
            v[16*i +: 16] = rot_elem();
        if (sel < 4)
            for (int i = 0; i < 3; i++)
                v[16*(4*i) +: 16] = (i + 1 == sel) ? 16'(16384 - $urandom_range(3000))
                                                   : 16'(-$urandom_range(16384));
        if (sel == 0)
            for (int i = 0; i < 3; i++)
                v[16*(4*i) +: 16] = 16'($urandom_range(16384));
        return v;
    endfunction

    task automatic send_item(logic [143:0] d);
        if (!calm)
            while ($urandom_range(99) < 12)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(matrix_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_item(matrix_item(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_item(matrix_item(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_item(matrix_item(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        send_item(matrix_item(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        send_item(matrix_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(matrix_item(-5000, 0, 0, 0, -5000, 0, 0, 0, -5000));
        send_item(matrix_item(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_item(matrix_item(-32768, 7, 9, 3, 32767, 1, 2, 5, 32767));
        send_item(matrix_item(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767));
        send_item(matrix_item(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        send_item(matrix_item(-32768, 32767, -32768, -32768, -32768, 32767,
                              32767, -32768, -32768));
        send_item(matrix_item(-16384, 1, 2, 3, -16384, 4, 5, 6, 32767));
        send_item(matrix_item(5, 100, -200, 300, 5, 32767, -32768, 9, 5));
        send_item(matrix_item(32767, -32768, 32767, 32767, -32768, -32768,
                              -32768, 32767, 32767));
        send_item(matrix_item(1, 32767, -32768, 0, 0, 0, 0, 0, -1));
        send_item(matrix_item(-16384, 0, 0, 0, -16384, 0, 0, 0, 0));
        drain();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 100)
                calm = 1'b1;
            if (n == 160)
                calm = 1'b0;
            if (n == 200)
                hold_req = 1'b1;
            if (n == 350)
                drain();
            if ($urandom_range(9) == 0)
            begin
                logic [143:0] noise;
                for (int i = 0; i < 9; i++)
                    noise[16*i +: 16] = 16'($urandom);
                send_item(noise);
            end
            else
                send_item(random_matrix());
        end
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS rotation_matrix_to_quaternion");
        else
            $display("FAIL rotation_matrix_to_quaternion");
        $finish;
    end

endmodule

FILE: rotation_matrix_to_quaternion.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_isqrt.sv
rtl/rmq_udiv.sv
rtl/rotation_matrix_to_quaternion.sv
sim/rmq_checker.sv
sim/tb_rotation_matrix_to_quaternion.sv
